// ===== design/wildcard_byte_signature_scan_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard byte signature scanner
// Clocked implication checks: same cycle, and next cycle with or without the reset disable.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define WBSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define WBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante, also while in reset.
`define WBSS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wbss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared types and constants of the wildcard byte signature scanner.
// ----------------------------------------------------------------------------
package wbss_pkg;

    // Signature register file holds this many byte positions.
    localparam int REG_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int START_W   = 32;
    localparam int IDX_W     = 4;
    localparam int CFG_W     = 64;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_PAT_LO  = 4'd0;
    localparam logic [IDX_W-1:0] CFG_PAT_HI  = 4'd1;
    localparam logic [IDX_W-1:0] CFG_WILD    = 4'd2;
    localparam logic [IDX_W-1:0] CFG_LENGTH  = 4'd3;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_MATCH   = 2'd1,
        ST_PENDING = 2'd2
    } status_t;

    typedef struct packed {
        logic [8*REG_BYTES-1:0] sig_bytes;
        logic [REG_BYTES-1:0]   wild_mask;
        logic [LEN_W-1:0]       length_raw;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_scan;
        logic       chunk_end;
    } item_t;

    typedef struct packed {
        status_t              scan_status;
        logic [START_W-1:0]   match_start;
        logic [LEN_W-1:0]     partial_length;
    } result_t;

endpackage

// ===== design/wbss_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_cfg
// Configuration register file: signature bytes, wildcard mask, length.
// ----------------------------------------------------------------------------
module wbss_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [wbss_pkg::IDX_W-1:0]   wr_index,
    input  logic [wbss_pkg::CFG_W-1:0]   wr_data,
    output wbss_pkg::cfg_t               cfg
);

    logic [wbss_pkg::CFG_W-1:0]     pat_lo_reg;
    logic [wbss_pkg::CFG_W-1:0]     pat_hi_reg;
    logic [wbss_pkg::REG_BYTES-1:0] wild_reg;
    logic [wbss_pkg::LEN_W-1:0]     length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            wild_reg   <= '0;
            length_reg <= wbss_pkg::LEN_W'(1);
        end else if (wr_en) begin
            case (wr_index)
                wbss_pkg::CFG_PAT_LO: pat_lo_reg <= wr_data;
                wbss_pkg::CFG_PAT_HI: pat_hi_reg <= wr_data;
                wbss_pkg::CFG_WILD:   wild_reg   <= wr_data[wbss_pkg::REG_BYTES-1:0];
                wbss_pkg::CFG_LENGTH: length_reg <= wr_data[wbss_pkg::LEN_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    assign cfg.sig_bytes  = {pat_hi_reg, pat_lo_reg};
    assign cfg.wild_mask  = wild_reg;
    assign cfg.length_raw = length_reg;

endmodule

// ===== design/wbss_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_core
// Shift-and matcher: scan state registers and the per-byte update logic.
// ----------------------------------------------------------------------------
module wbss_core #(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  wbss_pkg::cfg_t    cfg,
    input  wbss_pkg::item_t   item,
    input  logic              step,
    output wbss_pkg::result_t result
);

    localparam int CAP   = (MAX_PATTERN < wbss_pkg::REG_BYTES) ? MAX_PATTERN
                                                               : wbss_pkg::REG_BYTES;
    localparam int OFS_W = (POSITION_BITS > wbss_pkg::START_W) ? POSITION_BITS
                                                               : wbss_pkg::START_W;
    localparam int LW    = wbss_pkg::LEN_W;
    localparam int SW    = wbss_pkg::START_W;

    logic [CAP-1:0]           pv_reg,    pv_next;
    logic [POSITION_BITS-1:0] pos_reg,   pos_next;
    logic                     found_reg, found_next;
    logic [SW-1:0]            fo_reg,    fo_next;

    always_comb begin
        logic [CAP-1:0]           pv_cur;
        logic [POSITION_BITS-1:0] pos_cur;
        logic                     found_cur;
        logic [SW-1:0]            fo_cur;
        logic [LW-1:0]            len_eff;
        logic [CAP-1:0]           hits;
        logic [CAP-1:0]           lmask;
        logic [CAP-1:0]           nv;
        logic [LW-1:0]            plen;
        logic                     full;
        logic [OFS_W-1:0]         ofs_full;
        logic [OFS_W-1:0]         ofs_part;
        logic [POSITION_BITS-1:0] pos_step;

        // a new scan clears everything before this byte is looked at
        pv_cur    = item.new_scan ? '0 : pv_reg;
        pos_cur   = item.new_scan ? '0 : pos_reg;
        found_cur = item.new_scan ? 1'b0 : found_reg;
        fo_cur    = item.new_scan ? '0 : fo_reg;

        if (cfg.length_raw == '0) begin
            len_eff = LW'(1);
        end else if (cfg.length_raw > LW'(CAP)) begin
            len_eff = LW'(CAP);
        end else begin
            len_eff = cfg.length_raw;
        end

        for (int k = 0; k < CAP; k++) begin
            hits[k]  = cfg.wild_mask[k] | (cfg.sig_bytes[8*k +: 8] == item.data_byte);
            lmask[k] = (LW'(k) < len_eff);
        end

        nv = {pv_cur[CAP-2:0], 1'b1} & hits & lmask;

        plen = '0;
        full = 1'b0;
        for (int k = 0; k < CAP; k++) begin
            if (nv[k]) begin
                plen = LW'(k + 1);
            end
            if (nv[k] && (LW'(k + 1) == len_eff)) begin
                full = 1'b1;
            end
        end

        ofs_full = OFS_W'(pos_cur) - OFS_W'(len_eff - LW'(1));
        ofs_part = OFS_W'(pos_cur) - OFS_W'(plen - LW'(1));
        pos_step = (pos_cur == '1) ? pos_cur : pos_cur + POSITION_BITS'(1);

        pv_next    = pv_cur;
        pos_next   = pos_cur;
        found_next = found_cur;
        fo_next    = fo_cur;

        result.scan_status    = wbss_pkg::ST_NONE;
        result.match_start    = '0;
        result.partial_length = '0;

        if (found_cur) begin
            // hold after the first match
            result.match_start = fo_cur;
        end else begin
            pv_next  = nv;
            pos_next = pos_step;
            if (full) begin
                found_next            = 1'b1;
                fo_next               = ofs_full[SW-1:0];
                result.scan_status    = wbss_pkg::ST_MATCH;
                result.match_start    = ofs_full[SW-1:0];
                result.partial_length = len_eff;
            end else if (nv != '0) begin
                result.scan_status    = item.chunk_end ? wbss_pkg::ST_PENDING
                                                       : wbss_pkg::ST_NONE;
                result.match_start    = ofs_part[SW-1:0];
                result.partial_length = plen;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg    <= '0;
            pos_reg   <= '0;
            found_reg <= 1'b0;
            fo_reg    <= '0;
        end else if (step) begin
            pv_reg    <= pv_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
            fo_reg    <= fo_next;
        end
    end

endmodule

// ===== design/wildcard_byte_signature_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan
// Streaming search for a byte signature with per-position wildcards.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-------------------------------
//  s_       | in        | s_tvalid / s_tready    | tdata byte, tuser new scan,
//           |           |                        | tlast chunk end
//  m_       | out       | m_tvalid / m_tready    | tdata start + length,
//           |           |                        | tuser status
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One request per cycle sustained while m_tready stays high; each request
//  passes the input register, then the result register.
//  The scan state update (shift-and vector, position, found flag) is one
//  combinational step between the input register and the result register.
//  aresetn is synchronous and active low; it clears scan state and config.
//  A stall on m_tready holds the result register and the input register;
//  s_tready falls only when both are full and the output is stalled.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan #(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  logic                         s_tuser,   // [0] new_scan
    input  logic                         s_tlast,   // chunk_end

    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,   // [31:0] match_start,
                                                    // [36:32] partial_length,
                                                    // [39:37] zero
    output logic [1:0]                   m_tuser,   // [1:0] scan_status

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [wbss_pkg::IDX_W-1:0]   cfg_index,
    input  logic [wbss_pkg::CFG_W-1:0]   cfg_data
);

    wbss_pkg::cfg_t    cfg;
    wbss_pkg::result_t core_res;

    // Input register
    logic              in_valid_reg, in_valid_next;
    wbss_pkg::item_t   in_item_reg;

    // Result register
    logic              out_valid_reg, out_valid_next;
    wbss_pkg::result_t out_res_reg;

    logic              advance;
    logic              in_accept;

    assign cfg_ready = 1'b1;

    wbss_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held request when the result register is free or draining.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    wbss_core #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_item_reg),
        .step    (advance),
        .result  (core_res)
    );

    always_comb begin
        // hold unless a new request comes in or the current one moves on
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_item_reg.data_byte <= s_tdata;
            in_item_reg.new_scan  <= s_tuser;
            in_item_reg.chunk_end <= s_tlast;
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.partial_length, out_res_reg.match_start};
    assign m_tuser  = out_res_reg.scan_status;

endmodule

// ===== design/wbss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_checker
// Port-level checks on the scanner's result channel.
// ----------------------------------------------------------------------------
`include "wildcard_byte_signature_scan_defines.svh"

module wbss_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [39:0]                  m_tdata,
    input  logic [1:0]                   m_tuser
);

    // a stalled result holds its payload
    `WBSS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

    // match and pending reports always carry a nonzero length
    `WBSS_ASSERT_SAME(a_len, aclk, aresetn,
        m_tvalid && (m_tuser == wbss_pkg::ST_MATCH || m_tuser == wbss_pkg::ST_PENDING),
        m_tdata[36:32] != 5'd0, "match or pending report with zero length")

    // the result channel is empty on the cycle after a reset edge
    `WBSS_ASSERT_NEXT_ALWAYS(a_rst, aclk, !aresetn, !m_tvalid,
        "result valid right after reset")

    // pad bits stay zero and the length never exceeds the signature size
    `WBSS_ASSERT_SAME(a_pad, aclk, aresetn, m_tvalid,
        m_tdata[39:37] == 3'd0 && m_tdata[36:32] <= 5'd16, "bad result length field")

endmodule

bind wildcard_byte_signature_scan wbss_checker u_wbss_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the wildcard byte signature scanner against a shift-and predictor.
// A directed table covers reset defaults, wildcard and length corner cases,
// pending partials at chunk ends and the hold after a match. Random scans
// with embedded and broken signatures follow, under three idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    import wbss_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 100;
    localparam int SIG_POS      = 16;

    // Register index that decodes to nothing; writes to it must be dropped.
    localparam logic [IDX_W-1:0] CFG_NONE = 4'hF;
    localparam int IDX_TOP = (1 << IDX_W) - 1;

    // Two-letter alphabet for self-overlapping signatures.
    localparam logic [7:0] ALPHA_A = 8'h41;
    localparam logic [7:0] ALPHA_B = 8'h42;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    wildcard_byte_signature_scan u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // Predictor copy of the signature registers.
    logic [63:0] sig_lo;
    logic [63:0] sig_hi;
    logic [15:0] wild_bits;
    logic [4:0]  len_field;

    // Predictor copy of the scan state.
    logic [15:0] shift_vec;
    logic [31:0] scan_pos;
    logic        hit_seen;
    logic [31:0] hit_offset;

    // Results owed by the scanner, oldest first.
    result_t pending_results[$];

    int  send_idle_pct = 35;
    int  recv_idle_pct = 61;
    bit  failed = 1'b0;
    int  reports = 0;

    // Directed stimulus table: a register write or a byte, optionally with a
    // result that is plain from the setup.
    typedef struct {
        bit               is_write;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] value;
        logic [7:0]       b;
        logic             ns;
        logic             ce;
        bit               typed;
        result_t          want;
    } plan_row_t;

    plan_row_t plan[$];

    // Clamp the length field: zero acts as one, anything past the signature
    // store saturates to its size.
    function automatic int unsigned active_length();
        if (len_field == 5'd0)
            return 1;
        if (len_field > SIG_POS)
            return SIG_POS;
        return len_field;
    endfunction

    // Advance the predicted scan state by one byte and return its result.
    function automatic result_t scan_step(input logic [7:0] b, input logic ns, input logic ce);
        int unsigned len;
        int unsigned plen;
        int unsigned k;
        logic [127:0] sig;
        logic [15:0]  hits;
        logic [16:0]  len_mask;
        logic [31:0]  here;
        result_t      r;

        sig = {sig_hi, sig_lo};
        len = active_length();
        r.scan_status    = ST_NONE;
        r.match_start    = '0;
        r.partial_length = '0;

        if (ns) begin
            shift_vec  = '0;
            scan_pos   = '0;
            hit_seen   = 1'b0;
            hit_offset = '0;
        end

        // Hold after the first match: report its offset, advance nothing.
        if (hit_seen) begin
            r.match_start = hit_offset;
            return r;
        end

        hits = '0;
        for (k = 0; k < len; k++)
            if (wild_bits[k] || sig[k*8 +: 8] == b)
                hits[k] = 1'b1;
        len_mask  = (17'd1 << len) - 17'd1;
        shift_vec = ((shift_vec << 1) | 16'd1) & hits & len_mask[15:0];

        here = scan_pos;
        if (scan_pos != 32'hFFFF_FFFF)
            scan_pos = scan_pos + 32'd1;

        if (shift_vec[len-1]) begin
            hit_seen         = 1'b1;
            hit_offset       = here - 32'(len - 1);
            r.scan_status    = ST_MATCH;
            r.match_start    = hit_offset;
            r.partial_length = 5'(len);
        end else if (shift_vec != '0) begin
            plen = 0;
            for (k = 0; k < SIG_POS; k++)
                if (shift_vec[k])
                    plen = k + 1;
            r.scan_status    = ce ? ST_PENDING : ST_NONE;
            r.match_start    = here - 32'(plen - 1);
            r.partial_length = 5'(plen);
        end
        return r;
    endfunction

    function automatic plan_row_t w_row(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        plan_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.idx      = idx;
        row.value    = v;
        return row;
    endfunction

    function automatic plan_row_t b_row(input logic [7:0] b, input logic ns, input logic ce);
        plan_row_t row;
        row = '{default: '0};
        row.b  = b;
        row.ns = ns;
        row.ce = ce;
        return row;
    endfunction

    function automatic plan_row_t t_row(input logic [7:0] b, input logic ns, input logic ce,
                                        input status_t st, input logic [31:0] start,
                                        input logic [4:0] plen);
        plan_row_t row;
        row = b_row(b, ns, ce);
        row.typed                = 1'b1;
        row.want.scan_status     = st;
        row.want.match_start     = start;
        row.want.partial_length  = plen;
        return row;
    endfunction

    // Offer one byte, idling first at the current rate; record what it owes.
    task automatic send_byte(input logic [7:0] b, input logic ns, input logic ce,
                             input bit typed, input result_t typed_r);
        result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= ns;
        s_tlast  <= ce;
        do @(posedge aclk); while (!s_tready);
        r = scan_step(b, ns, ce);
        pending_results.push_back(typed ? typed_r : r);
    endtask

    // Stop offering bytes and wait until the scanner has nothing in flight.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register write request; cfg_valid stays high for a following write.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_PAT_LO: sig_lo    = v;
            CFG_PAT_HI: sig_hi    = v;
            CFG_WILD:   wild_bits = v[15:0];
            CFG_LENGTH: len_field = v[4:0];
            default: ;
        endcase
    endtask

    // Pick a new signature, leaning toward short lengths and overlap-prone
    // byte sets, with the register extremes mixed in.
    task automatic load_random_signature();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] wm;
        logic [4:0]  lf;
        int unsigned sel;
        int unsigned k;

        sel = $urandom_range(99);
        if (sel < 40) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
        end else if (sel < 80) begin
            for (k = 0; k < 8; k++) begin
                lo[k*8 +: 8] = $urandom_range(1) ? ALPHA_A : ALPHA_B;
                hi[k*8 +: 8] = $urandom_range(1) ? ALPHA_A : ALPHA_B;
            end
        end else if (sel < 90) begin
            lo = '0;
            hi = '0;
        end else begin
            lo = '1;
            hi = '1;
        end

        sel = $urandom_range(99);
        if (sel < 50)
            wm = '0;
        else if (sel < 80)
            wm = 16'($urandom & $urandom & $urandom);
        else if (sel < 90)
            wm = '1;
        else
            wm = 16'($urandom);

        sel = $urandom_range(99);
        if (sel < 60)
            lf = 5'($urandom_range(6, 1));
        else if (sel < 75)
            lf = 5'($urandom_range(15, 7));
        else if (sel < 85)
            lf = 5'(SIG_POS);
        else if (sel < 92)
            lf = '0;
        else
            lf = 5'($urandom_range(31, SIG_POS + 1));

        drain();
        write_reg(CFG_PAT_LO, lo);
        write_reg(CFG_PAT_HI, hi);
        write_reg(CFG_WILD, {48'd0, wm});
        write_reg(CFG_LENGTH, {59'd0, lf});
        // Sometimes hit an unused index with junk; it must change nothing.
        if ($urandom_range(4) == 0)
            write_reg(IDX_W'($urandom_range(IDX_TOP, CFG_LENGTH + 1)),
                      {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // Filler byte that often agrees with some signature position.
    function automatic logic [7:0] signature_like_byte();
        logic [127:0] sig;
        int unsigned  sel;
        sig = {sig_hi, sig_lo};
        sel = $urandom_range(99);
        if (sel < 50)
            return sig[$urandom_range(active_length() - 1) * 8 +: 8];
        if (sel < 65)
            return $urandom_range(1) ? ALPHA_A : ALPHA_B;
        return 8'($urandom_range(255));
    endfunction

    // Result side: stall at random, check every accepted result in order.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    failed = 1'b1;
                    if (reports < MAX_REPORTS)
                        $error("unexpected result: status %0d start %0d length %0d",
                               m_tuser, m_tdata[31:0], m_tdata[36:32]);
                    reports++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.scan_status) begin
                        failed = 1'b1;
                        if (reports < MAX_REPORTS)
                            $error("scan_status: expected %0d, got %0d",
                                   want.scan_status, m_tuser);
                        reports++;
                    end
                    if (m_tdata[31:0] !== want.match_start) begin
                        failed = 1'b1;
                        if (reports < MAX_REPORTS)
                            $error("match_start: expected %0d, got %0d",
                                   want.match_start, m_tdata[31:0]);
                        reports++;
                    end
                    if (m_tdata[36:32] !== want.partial_length) begin
                        failed = 1'b1;
                        if (reports < MAX_REPORTS)
                            $error("partial_length: expected %0d, got %0d",
                                   want.partial_length, m_tdata[36:32]);
                        reports++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int i;
        int sent;
        int scans_left;
        int noise;
        int k;
        int unsigned len;
        logic ns;
        logic [7:0] b;
        logic [127:0] sig;

        // Predictor starts from the reset values.
        sig_lo     = '0;
        sig_hi     = '0;
        wild_bits  = '0;
        len_field  = 5'd1;
        shift_vec  = '0;
        scan_pos   = '0;
        hit_seen   = 1'b0;
        hit_offset = '0;

        // Hold reset, then release it for good.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: one zero byte is the whole signature.
        plan.push_back(t_row(8'h00, 1'b0, 1'b0, ST_MATCH, 32'd0, 5'd1));
        // Held after the match, even a chunk end reports nothing.
        plan.push_back(t_row(8'hFF, 1'b0, 1'b1, ST_NONE, 32'd0, 5'd0));
        plan.push_back(t_row(8'hFF, 1'b1, 1'b0, ST_NONE, 32'd0, 5'd0));
        plan.push_back(t_row(8'h00, 1'b0, 1'b0, ST_MATCH, 32'd1, 5'd1));
        plan.push_back(t_row(8'h7E, 1'b0, 1'b0, ST_NONE, 32'd1, 5'd0));

        // DE AD ?? EF: grow a partial, park it at a chunk end, complete it.
        plan.push_back(w_row(CFG_PAT_LO, 64'h0000_0000_EF00_ADDE));
        plan.push_back(w_row(CFG_WILD, 64'h0004));
        plan.push_back(w_row(CFG_LENGTH, 64'd4));
        plan.push_back(t_row(8'hDE, 1'b1, 1'b0, ST_NONE, 32'd0, 5'd1));
        plan.push_back(t_row(8'hAD, 1'b0, 1'b0, ST_NONE, 32'd0, 5'd2));
        plan.push_back(t_row(8'h55, 1'b0, 1'b1, ST_PENDING, 32'd0, 5'd3));
        plan.push_back(t_row(8'hEF, 1'b0, 1'b0, ST_MATCH, 32'd0, 5'd4));
        // Chunk end with nothing pending stays quiet.
        plan.push_back(t_row(8'h00, 1'b1, 1'b1, ST_NONE, 32'd0, 5'd0));
        // Restart inside a partial: the match begins at the second byte.
        plan.push_back(b_row(8'hDE, 1'b1, 1'b0));
        plan.push_back(b_row(8'hDE, 1'b0, 1'b0));
        plan.push_back(b_row(8'hAD, 1'b0, 1'b0));
        plan.push_back(b_row(8'h77, 1'b0, 1'b1));
        plan.push_back(b_row(8'hEF, 1'b0, 1'b0));

        // Length field zero acts as one; a wildcard matches any byte.
        plan.push_back(w_row(CFG_WILD, 64'h0001));
        plan.push_back(w_row(CFG_LENGTH, 64'd0));
        plan.push_back(t_row(8'h5A, 1'b1, 1'b0, ST_MATCH, 32'd0, 5'd1));
        // Unused index: everything stays as it was.
        plan.push_back(w_row(CFG_NONE, '1));
        plan.push_back(t_row(8'h33, 1'b1, 1'b0, ST_MATCH, 32'd0, 5'd1));

        // All-ones signature, length field past the top saturates to 16.
        plan.push_back(w_row(CFG_PAT_LO, '1));
        plan.push_back(w_row(CFG_PAT_HI, '1));
        plan.push_back(w_row(CFG_WILD, 64'h0));
        plan.push_back(w_row(CFG_LENGTH, 64'd31));
        plan.push_back(t_row(8'hFF, 1'b1, 1'b0, ST_NONE, 32'd0, 5'd1));
        plan.push_back(t_row(8'hFF, 1'b0, 1'b0, ST_NONE, 32'd0, 5'd2));
        plan.push_back(t_row(8'hFF, 1'b0, 1'b1, ST_PENDING, 32'd0, 5'd3));

        for (i = 0; i < plan.size(); i++) begin
            if (plan[i].is_write) begin
                if (i == 0 || !plan[i-1].is_write)
                    drain();
                write_reg(plan[i].idx, plan[i].value);
                if (i == plan.size() - 1 || !plan[i+1].is_write)
                    cfg_valid <= 1'b0;
            end else begin
                send_byte(plan[i].b, plan[i].ns, plan[i].ce, plan[i].typed, plan[i].want);
            end
        end

        // Random scans: noise, then usually the signature with random bytes
        // at wildcard positions (now and then a byte with one bit flipped), then a tail
        // that the hold after a match mostly swallows.
        sent = 0;
        scans_left = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (sent >= RANDOM_ITEMS / 3) begin
                send_idle_pct = 61;
                recv_idle_pct = 35;
            end

            if (scans_left == 0) begin
                load_random_signature();
                scans_left = $urandom_range(8, 3);
            end
            scans_left--;

            ns = ($urandom_range(9) != 0);
            noise = $urandom_range(12);
            for (k = 0; k < noise; k++) begin
                send_byte(signature_like_byte(), ns | ($urandom_range(39) == 0),
                          ($urandom_range(5) == 0), 1'b0, '0);
                ns = 1'b0;
                sent++;
            end

            if ($urandom_range(9) < 7) begin
                sig = {sig_hi, sig_lo};
                len = active_length();
                for (k = 0; k < len; k++) begin
                    b = wild_bits[k] ? 8'($urandom_range(255)) : sig[k*8 +: 8];
                    if ($urandom_range(19) == 0)
                        b = b ^ (8'd1 << $urandom_range(7));
                    send_byte(b, ns, ($urandom_range(5) == 0), 1'b0, '0);
                    ns = 1'b0;
                    sent++;
                end
            end

            noise = $urandom_range(4);
            for (k = 0; k < noise; k++) begin
                send_byte(8'($urandom_range(255)), ns, ($urandom_range(3) == 0), 1'b0, '0);
                ns = 1'b0;
                sent++;
            end
        end

        // Let every owed result arrive, plus a margin for stray output.
        drain();
        repeat (10) @(posedge aclk);
        if (!failed && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== wildcard_byte_signature_scan.f =====
+incdir+design
design/wbss_pkg.sv
design/wbss_cfg.sv
design/wbss_core.sv
design/wildcard_byte_signature_scan.sv
design/wbss_checker.sv
tb/sv/testbench.sv
